FILE: rtl/pie_pkg.sv
// Shared types, constants and codes for the postfix integer evaluator.
package pie_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 16;
    localparam int unsigned DATA_WIDTH_DEF  = 32;
    localparam int unsigned CMD_W           = 3;
    localparam int unsigned ERR_W           = 2;
    localparam int unsigned LIMIT_W         = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MOD  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_AND  = 3'd5,
        CMD_XOR  = 3'd6,
        CMD_END  = 3'd7
    } t_cmd;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_STACK = 2'd1,
        ERR_DIV0  = 2'd2,
        ERR_OVF   = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EXEC,
        ST_DIV,
        ST_DFIX,
        ST_OUT
    } t_state;

endpackage

FILE: rtl/pie_front.sv
// Front end: token limit, counting and a two-entry queue toward the executor.
module pie_front #(
    parameter int unsigned DATA_WIDTH = pie_pkg::DATA_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pie_pkg::LIMIT_W-1:0] i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [pie_pkg::CMD_W-1:0]   i_cmd,
    input  logic [DATA_WIDTH-1:0]       i_number,
    output logic                        o_q_valid,
    input  logic                        i_q_pop,
    output logic [pie_pkg::CMD_W-1:0]   o_q_cmd,
    output logic [DATA_WIDTH-1:0]       o_q_number
);
    import pie_pkg::*;

    logic [LIMIT_W-1:0]    r_limit;
    logic [LIMIT_W-1:0]    r_seen, n_seen;
    logic [CMD_W-1:0]      r_qcmd [2];
    logic [DATA_WIDTH-1:0] r_qnum [2];
    logic                  r_wp, r_rp;
    logic [1:0]            r_cnt;
    logic                  acc, keep, pop;

    assign o_stall    = (r_cnt == 2'd2);
    assign acc        = i_valid && !o_stall;
    // tokens beyond the limit are dropped here and never reach the executor
    assign keep       = (i_cmd == CMD_END) || (r_seen < r_limit);
    assign pop        = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_cmd    = r_qcmd[r_rp];
    assign o_q_number = r_qnum[r_rp];

    always_comb begin
        n_seen = r_seen;
        if (acc) begin
            if (i_cmd == CMD_END) n_seen = '0;
            else if (keep) n_seen = r_seen + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_seen  <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            r_seen <= n_seen;
            if (acc && keep) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, acc && keep} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && keep) begin
            r_qcmd[r_wp] <= i_cmd;
            r_qnum[r_wp] <= i_number;
        end
    end

endmodule

FILE: rtl/pie_div.sv
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
module pie_div #(
    parameter int unsigned DATA_WIDTH = pie_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_quot,
    output logic [DATA_WIDTH-1:0] o_rem
);
    localparam int unsigned CW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] r_q, r_d;
    logic [DATA_WIDTH:0]   r_r;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic [DATA_WIDTH:0]   shifted, diff;

    assign shifted = {r_r[DATA_WIDTH-1:0], r_q[DATA_WIDTH-1]};
    assign diff    = shifted - {1'b0, r_d};
    assign o_done  = r_busy && (r_cnt == '0);
    assign o_quot  = r_q;
    assign o_rem   = r_r[DATA_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DATA_WIDTH);
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_d <= i_divisor;
            r_r <= '0;
        end else if (r_busy && r_cnt != '0) begin
            if (!diff[DATA_WIDTH]) begin
                r_r <= diff;
                r_q <= {r_q[DATA_WIDTH-2:0], 1'b1};
            end else begin
                r_r <= shifted;
                r_q <= {r_q[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

endmodule

FILE: rtl/pie_back.sv
// Back end: operand stack memory, operator execution and result register.
module pie_back #(
    parameter int unsigned STACK_DEPTH = pie_pkg::STACK_DEPTH_DEF,
    parameter int unsigned DATA_WIDTH  = pie_pkg::DATA_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  logic [pie_pkg::CMD_W-1:0]   i_q_cmd,
    input  logic [DATA_WIDTH-1:0]       i_q_number,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [DATA_WIDTH-1:0]       o_value,
    output logic [pie_pkg::ERR_W-1:0]   o_error
);
    import pie_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DATA_WIDTH-1:0] WMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    t_state r_state, n_state;
    logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] r_a, r_b, r_top;
    logic [DW-1:0]         r_depth;
    logic [ERR_W-1:0]      r_err;
    logic [CMD_W-1:0]      r_cmd;
    logic [DATA_WIDTH-1:0] r_res;
    logic                  r_ovalid;
    logic [DATA_WIDTH-1:0] r_oval;
    logic [ERR_W-1:0]      r_oerr;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [DATA_WIDTH-1:0] mem_wd;
    logic                  na, nb, div_start, div_done;
    logic [DATA_WIDTH-1:0] ma, mb, quot, remd, dres, exres;
    logic                  take, is_push, is_end, under;

    assign take    = (r_state == ST_IDLE) && i_q_valid && !(r_ovalid && i_stall);
    assign o_q_pop = take;
    assign is_push = (i_q_cmd == CMD_PUSH);
    assign is_end  = (i_q_cmd == CMD_END);
    assign under   = (r_depth < DW'(2));
    assign na = r_a[DATA_WIDTH-1];
    assign nb = r_b[DATA_WIDTH-1];
    assign ma = na ? -r_a : r_a;
    assign mb = nb ? -r_b : r_b;
    assign div_start = (r_state == ST_EXEC) && (r_cmd == CMD_DIV || r_cmd == CMD_MOD)
                       && (r_b != '0);

    pie_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(ma), .i_divisor(mb), .o_done(div_done),
        .o_quot(quot), .o_rem(remd)
    );

    assign dres = (r_cmd == CMD_DIV) ? ((na != nb) ? -quot : quot)
                                     : (na ? -remd : remd);

    always_comb begin
        case (r_cmd)
            CMD_ADD: exres = r_a + r_b;
            CMD_SUB: exres = r_a - r_b;
            CMD_AND: exres = r_a & r_b;
            CMD_XOR: exres = r_a ^ r_b;
            default: exres = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (take && is_end) n_state = ST_OUT;
                else if (take && !is_push && !under) n_state = ST_RD;
            end
            ST_RD:   n_state = ST_EXEC;
            ST_EXEC: n_state = div_start ? ST_DIV : ST_IDLE;
            ST_DIV:  if (div_done) n_state = ST_DFIX;
            ST_DFIX: n_state = ST_IDLE;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // writes to the stack memory
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_depth[AW-1:0];
        mem_wd = i_q_number;
        unique case (r_state)
            ST_IDLE: begin
                if (take && is_push && r_depth < DW'(STACK_DEPTH)) mem_we = 1'b1;
            end
            ST_EXEC: begin
                mem_wa = AW'(r_depth - DW'(2));
                mem_wd = exres;
                mem_we = !div_start;
            end
            ST_DFIX: begin
                mem_wa = AW'(r_depth - DW'(2));
                mem_wd = r_res;
                mem_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_top <= mem[AW'(r_depth - DW'(1))];
        r_a   <= mem[AW'(r_depth - DW'(2))];
        if (r_state == ST_IDLE) r_cmd <= i_q_cmd;
        if (div_done) r_res <= dres;
        if (r_state == ST_RD) r_b <= r_top;
    end

    // reading a pair: r_top holds top after idle cycle, r_a second entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_depth  <= '0;
            r_err    <= ERR_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (take) begin
                if (is_push) begin
                    if (r_depth < DW'(STACK_DEPTH)) r_depth <= r_depth + 1'b1;
                    else if (r_err == ERR_OK) r_err <= ERR_STACK;
                end else if (!is_end && under && r_err == ERR_OK) begin
                    r_err <= ERR_STACK;
                end
            end
            // top was read at the edge that took the end token
            if (r_state == ST_OUT) begin
                r_ovalid <= 1'b1;
                r_oval   <= (r_depth == '0) ? '0 : r_top;
                r_oerr   <= r_err;
                r_depth  <= '0;
                r_err    <= ERR_OK;
            end
            if (r_state == ST_EXEC) begin
                if ((r_cmd == CMD_DIV || r_cmd == CMD_MOD) && r_b == '0) begin
                    if (r_err == ERR_OK) r_err <= ERR_DIV0;
                end
                if (!div_start) r_depth <= r_depth - 1'b1;
            end
            if (r_state == ST_DFIX) begin
                r_depth <= r_depth - 1'b1;
                if (r_cmd == CMD_DIV && r_a == WMIN && r_b == '1 && r_err == ERR_OK)
                    r_err <= ERR_OVF;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_value = r_oval;
    assign o_error = r_oerr;

endmodule

FILE: rtl/postfix_integer_evaluator_unit.sv
// Top level of the postfix integer evaluator.
// Usage:
// - Input channel: i_valid/o_stall carry one token beat (i_cmd, i_number).
// - Output channel: o_valid/i_stall carry one result beat (o_value, o_error),
//   produced only for an end token.
// - i_cfg_we/i_cfg_data write the token limit; write only while idle.
// - A front stage applies the token limit and feeds a two-entry queue.
// - The back stage takes push tokens directly; end tokens pass through
//   stack read and result; add, subtract, and, xor pass through
//   stack read, operand move and execute.
// - Divide and modulo pass through stack read, operand move and execute,
//   then the one-bit-per-cycle divider and a fix-up and write-back step.
// - End results are formed in the ST_OUT state and registered for output.
// - While the output is stalled the result register holds and the back
//   stage takes no further token until the result beat is accepted.
// - Synchronous reset clears the stack depth, token count, error and
//   valid flags; the token limit returns to 10.
module postfix_integer_evaluator_unit #(
    parameter int unsigned STACK_DEPTH = pie_pkg::STACK_DEPTH_DEF,
    parameter int unsigned DATA_WIDTH  = pie_pkg::DATA_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pie_pkg::LIMIT_W-1:0] i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [pie_pkg::CMD_W-1:0]   i_cmd,
    input  logic [DATA_WIDTH-1:0]       i_number,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [DATA_WIDTH-1:0]       o_value,
    output logic [pie_pkg::ERR_W-1:0]   o_error
);
    import pie_pkg::*;

    logic                  q_valid, q_pop;
    logic [CMD_W-1:0]      q_cmd;
    logic [DATA_WIDTH-1:0] q_number;

    pie_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_number(i_number),
        .o_q_valid(q_valid), .i_q_pop(q_pop),
        .o_q_cmd(q_cmd), .o_q_number(q_number)
    );

    pie_back #(.STACK_DEPTH(STACK_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_q_cmd(q_cmd), .i_q_number(q_number),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_value(o_value), .o_error(o_error)
    );

endmodule
